[hw/rtl/pfgr_pkg.sv]
// Package for the page frame buffer glyph renderer.
// Holds screen constants, the 5x7 font, command and control types.
// No dependencies.
package pfgr_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int STORE_DEPTH   = 1024;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;

	localparam logic [2:0] OP_CLEAR = 3'd0;
	localparam logic [2:0] OP_PIXEL = 3'd1;
	localparam logic [2:0] OP_GLYPH = 3'd2;
	localparam logic [2:0] OP_HLINE = 3'd3;
	localparam logic [2:0] OP_BARS  = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST  = 8'h7E;
	localparam logic [6:0] CHAR_QMARK = 7'h1F;
	localparam logic signed [7:0] BAR_LIMIT0 = -8'sd90;
	localparam logic signed [7:0] BAR_LIMIT1 = -8'sd70;
	localparam logic signed [7:0] BAR_LIMIT2 = -8'sd55;
	localparam logic signed [7:0] BAR_LIMIT3 = -8'sd40;
	localparam logic signed [9:0] GLYPH_ADVANCE = 10'sd6;

	typedef enum logic [1:0] {K_NOP, K_CLEAR, K_DRAW, K_READ} kind_t;
	typedef enum logic [1:0] {D_PIXEL, D_GLYPH, D_HLINE, D_BARS} draw_t;
	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_WR, S_RDA, S_RDW, S_CLR, S_DONE
	} state_t;

	typedef struct packed {
		kind_t                   kind;
		draw_t                   draw;
		logic signed [9:0]       x0;
		logic [8:0]              ncol;
		logic signed [8:0]       y;
		logic [6:0]              glyph;
		logic [STORE_AW-1:0]     read_addr;
		logic signed [9:0]       next_x;
	} cmd_t;

	typedef struct packed {
		logic init_done;
		logic pop;
	} back_status_t;

	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] waddr;
		logic [7:0]          wdata;
		logic [STORE_AW-1:0] raddr;
	} mem_req_t;

	// Columns of each printable glyph, left column in the top byte.
	localparam logic [39:0] GLYPH_ROM [95] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
		40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
		40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
		40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
		40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
		40'h00007F0000, 40'h0041360800, 40'h1008081008
	};

	function automatic logic [6:0] glyph_col(logic [6:0] idx, logic [2:0] col);
		logic [39:0] row;
		logic [7:0]  b;
		row = (idx < 7'd95) ? GLYPH_ROM[idx] : '0;
		case (col)
			3'd0:    b = row[39:32];
			3'd1:    b = row[31:24];
			3'd2:    b = row[23:16];
			3'd3:    b = row[15:8];
			3'd4:    b = row[7:0];
			default: b = '0;
		endcase
		return b[6:0];
	endfunction

	// Rows of a page that fall inside the screen.
	function automatic logic [7:0] row_mask(logic signed [7:0] pg);
		logic [7:0] m;
		for (int k = 0; k < 8; k++) begin
			m[k] = (int'(pg) * 8 + k < SCREEN_HEIGHT);
		end
		return m;
	endfunction

endpackage

[hw/rtl/pfgr_in_if.sv]
// Request channel of the glyph renderer: valid/ready plus the drawing fields.
// Standalone; no package dependency.
interface pfgr_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic signed [8:0] x_pos;
	logic signed [8:0] y_pos;
	logic signed [8:0] x_end;
	logic [7:0]        char_code;
	logic signed [7:0] signal_level;
	logic [9:0]        read_addr;

	modport source (output valid, opcode, x_pos, y_pos, x_end, char_code,
		signal_level, read_addr, input ready);
	modport sink (input valid, opcode, x_pos, y_pos, x_end, char_code,
		signal_level, read_addr, output ready);
endinterface

[hw/rtl/pfgr_out_if.sv]
// Result channel of the glyph renderer: valid/ready plus read data and next x.
// Standalone; no package dependency.
interface pfgr_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        read_data;
	logic signed [9:0] next_x;

	modport source (output valid, read_data, next_x, input ready);
	modport sink (input valid, read_data, next_x, output ready);
endinterface

[hw/rtl/pfgr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/pfgr_front.sv]
// Front end: accept requests, classify and clip them, queue two commands.
// Depends on pfgr_pkg and pfgr_in_if.
module pfgr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	pfgr_in_if.sink               item,
	input  pfgr_pkg::back_status_t st,
	output pfgr_pkg::cmd_t        cmd,
	output logic                  cmd_valid
);
	import pfgr_pkg::*;

	cmd_t       cls;
	cmd_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push;

	logic signed [9:0] xs, xe, span;
	logic [2:0]        nbars;

	always_comb begin
		cls = '0;
		cls.x0        = 10'(item.x_pos);
		cls.y         = item.y_pos;
		cls.read_addr = item.read_addr;
		cls.next_x    = 10'(item.x_pos);
		cls.glyph     = (item.char_code < CHAR_FIRST || item.char_code > CHAR_LAST)
			? CHAR_QMARK : 7'(item.char_code - CHAR_FIRST);
		// clip the line to the visible columns
		xs   = (item.x_pos < 0) ? 10'sd0 : 10'(item.x_pos);
		xe   = (10'(item.x_end) > 10'(SCREEN_WIDTH - 1)) ? 10'(SCREEN_WIDTH - 1)
			: 10'(item.x_end);
		span = xe - xs + 10'sd1;
		nbars = 3'(item.signal_level >= BAR_LIMIT0) + 3'(item.signal_level >= BAR_LIMIT1)
			+ 3'(item.signal_level >= BAR_LIMIT2) + 3'(item.signal_level >= BAR_LIMIT3);
		cls.kind = K_NOP;
		cls.draw = D_PIXEL;
		unique case (item.opcode)
			OP_CLEAR: cls.kind = K_CLEAR;
			OP_PIXEL: begin
				cls.kind = K_DRAW;
				cls.ncol = 9'd1;
			end
			OP_GLYPH: begin
				cls.kind   = K_DRAW;
				cls.draw   = D_GLYPH;
				cls.ncol   = 9'd5;
				cls.next_x = 10'(item.x_pos) + GLYPH_ADVANCE;
			end
			OP_HLINE: begin
				cls.kind = K_DRAW;
				cls.draw = D_HLINE;
				cls.x0   = xs;
				cls.ncol = (xe < xs) ? 9'd0 : span[8:0];
			end
			OP_BARS: begin
				cls.kind = K_DRAW;
				cls.draw = D_BARS;
				cls.ncol = 9'(nbars) * 9'd3;
			end
			OP_READ: cls.kind = K_READ;
			default: cls.kind = K_NOP;
		endcase
	end

	assign item.ready = st.init_done && (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign cmd        = ent_q[rp_q];
	assign cmd_valid  = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (st.pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(st.pop);
		end
	end
endmodule

[hw/rtl/pfgr_back.sv]
// Back end: walk columns and page bytes by read-modify-write, clear, read back.
// Depends on pfgr_pkg and pfgr_out_if; drives the frame store ports.
module pfgr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pfgr_pkg::cmd_t         cmd,
	input  logic                   cmd_valid,
	output pfgr_pkg::back_status_t st,
	output pfgr_pkg::mem_req_t     mem,
	input  logic [7:0]             rdata,
	pfgr_out_if.source             result
);
	import pfgr_pkg::*;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [8:0]          c_q;
	logic                j_q;
	logic [STORE_AW-1:0] clr_q, addr_q;
	logic [7:0]          mask_q, data_q;
	logic                ok_q, init_q, ovalid_q;
	logic [7:0]          odata_q;
	logic signed [9:0]   onext_q;

	logic signed [10:0] cx, base;
	logic [8:0]         pat;
	logic [3:0]         bar;
	logic signed [7:0]  pg;
	logic [15:0]        sh;
	logic [7:0]         bmask;
	logic [12:0]        addr;
	logic               ok, load_out, last_clr;

	// column pattern and address of the current byte
	always_comb begin
		cx   = 11'(cmd_q.x0) + 11'(c_q);
		base = 11'(cmd_q.y);
		pat  = 9'd1;
		bar  = (c_q >= 9'd9) ? 4'd3 : (c_q >= 9'd6) ? 4'd2 : (c_q >= 9'd3) ? 4'd1 : 4'd0;
		case (cmd_q.draw)
			D_GLYPH: pat = 9'(glyph_col(cmd_q.glyph, c_q[2:0]));
			D_BARS: begin
				pat  = (c_q[3:0] == bar * 4'd3 + 4'd2) ? 9'd0
					: 9'((10'd1 << (4'd3 + 4'd2 * bar)) - 10'd1);
				base = 11'(cmd_q.y) - 11'sd2 - 11'(signed'({1'b0, bar, 1'b0}));
			end
			default: pat = 9'd1;
		endcase
		pg    = 8'(base >>> 3) + 8'(j_q);
		sh    = 16'(pat) << base[2:0];
		bmask = (j_q ? sh[15:8] : sh[7:0]) & row_mask(pg);
		addr  = 13'(cx[7:0]) + 13'(pg[3:0]) * 13'(SCREEN_WIDTH);
		ok    = (cx >= 0) && (cx < 11'(SCREEN_WIDTH)) && (pg >= 0) && (pg < 8'(PAGES))
			&& (addr < 13'(STORE_DEPTH)) && (bmask != 8'd0);
	end

	assign last_clr = (clr_q == STORE_AW'(STORE_DEPTH - 1));
	assign load_out = (state_q == S_DONE) && (!ovalid_q || result.ready);

	always_comb begin
		state_d      = state_q;
		st.init_done = init_q;
		st.pop       = 1'b0;
		mem          = '0;
		mem.raddr    = addr[STORE_AW-1:0];
		unique case (state_q)
			S_INIT, S_CLR: begin
				mem.we    = 1'b1;
				mem.waddr = clr_q;
				if (last_clr) begin
					state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
				end
			end
			S_IDLE: begin
				if (cmd_valid) begin
					st.pop = 1'b1;
					unique case (cmd.kind)
						K_CLEAR: state_d = S_CLR;
						K_READ:  state_d = S_RDA;
						K_DRAW:  state_d = (cmd.ncol == 9'd0) ? S_DONE : S_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RD: state_d = S_WR;
			S_WR: begin
				mem.we    = ok_q;
				mem.waddr = addr_q;
				mem.wdata = rdata | mask_q;
				if (j_q && (c_q + 9'd1 == cmd_q.ncol)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_RDA: begin
				mem.raddr = cmd_q.read_addr;
				state_d   = S_RDW;
			end
			S_RDW: state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign result.valid     = ovalid_q;
	assign result.read_data = odata_q;
	assign result.next_x    = onext_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q  <= cmd;
			data_q <= '0;
		end
		if (state_q == S_RD) begin
			addr_q <= addr[STORE_AW-1:0];
			mask_q <= bmask;
			ok_q   <= ok;
		end
		if (state_q == S_RDW) begin
			data_q <= rdata;
		end
		if (load_out) begin
			odata_q <= data_q;
			onext_q <= cmd_q.next_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			clr_q    <= '0;
			c_q      <= '0;
			j_q      <= 1'b0;
			init_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT || state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_INIT && last_clr) begin
				init_q <= 1'b1;
			end
			if (state_q == S_IDLE) begin
				c_q <= '0;
				j_q <= 1'b0;
			end else if (state_q == S_WR) begin
				j_q <= ~j_q;
				if (j_q) begin
					c_q <= c_q + 9'd1;
				end
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (result.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

[hw/rtl/page_framebuffer_glyph_renderer.sv]
// One request at a time in the back end, up to two queued ahead; the back end
// takes a new request only after it has loaded the last one's result into the
// output register.
// Rate is set by the frame store: each page byte is a read then a write,
// two bytes per column, and a clear writes one byte per cycle.
// Reset: asynchronous, active low; a clearing pass over all 1024 store bytes
// follows, during which item.ready stays low.
module page_framebuffer_glyph_renderer (
	input  logic      clk,
	input  logic      arst_n,
	pfgr_in_if.sink   item,
	pfgr_out_if.source result
);
	import pfgr_pkg::*;

	// queue between classifier and executor
	cmd_t         cmd;
	logic         cmd_valid;
	back_status_t st;

	// frame store port
	mem_req_t     mem;
	logic [7:0]   rdata;

	// accept, classify, clip; hold up to two commands
	pfgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.st        (st),
		.cmd       (cmd),
		.cmd_valid (cmd_valid)
	);

	// run commands against the store and present results
	pfgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.st        (st),
		.mem       (mem),
		.rdata     (rdata),
		.result    (result)
	);

	// page-organized frame store, one byte per column per page
	pfgr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

`ifndef ASSERT_OFF
	// hold off requests until the clearing pass is over
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		!st.init_done |-> !item.ready) else $error("request accepted during init");
	// pop only a queued command
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st.pop |-> cmd_valid) else $error("pop from empty queue");
	// the clearing pass writes zeros only
	a_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(mem.we && !st.init_done) |-> (mem.wdata == 8'd0)) else $error("init writes data");
	// init ends right after a store write
	a_init_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st.init_done) |-> $past(mem.we)) else $error("init ended early");
`endif
endmodule
